>>> hdl/drae_pkg.sv
// Shared types and constants for the download rate average estimator.
package drae_pkg;

    localparam int unsigned BYTES_W      = 32;
    localparam int unsigned TIME_W       = 32;
    // byte_count * 8000 always fits in 45 bits.
    localparam int unsigned SCALED_W     = 45;
    localparam int unsigned SCALE        = 8000;
    localparam int unsigned PERIOD_W     = 8;
    localparam int unsigned PERIOD_RESET = 5;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned PRDATA_W     = 32;
    localparam int unsigned PADDR_W      = 3;

    localparam logic [PADDR_W-1:0] ADDR_PUBLISH_PERIOD = 3'd0;

    // One classified word waiting for the back end.
    typedef struct packed {
        logic                ignored;
        logic [SCALED_W-1:0] dividend;
        logic [TIME_W-1:0]   divisor;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RATE_DIV,
        ST_AVG_DIV
    } t_back_state;

endpackage

>>> hdl/drae_front.sv
// Front end: accepts download reports, flags zero durations and scales the byte count.
module drae_front (
    input  logic                                  push,
    output logic                                  full,
    input  logic [drae_pkg::BYTES_W-1:0]          i_byte_count,
    input  logic [drae_pkg::TIME_W-1:0]           i_elapsed_time,
    input  logic                                  i_q_full,
    output logic                                  o_q_push,
    output drae_pkg::t_item                       o_q_item
);

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    always_comb begin
        o_q_item.ignored  = (i_elapsed_time == '0);
        o_q_item.dividend = drae_pkg::SCALED_W'(i_byte_count)
                          * drae_pkg::SCALED_W'(drae_pkg::SCALE);
        o_q_item.divisor  = i_elapsed_time;
    end

endmodule

>>> hdl/drae_queue.sv
// Short queue of classified words between the front end and the back end.
module drae_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  drae_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output drae_pkg::t_item o_head
);

    localparam int unsigned PTR_W = (drae_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(drae_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(drae_pkg::QUEUE_DEPTH + 1);

    drae_pkg::t_item  r_mem [drae_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(drae_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(drae_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(drae_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hdl/drae_divider.sv
// Restoring divider producing one quotient bit per cycle.
module drae_divider #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_numer,
    input  logic [DEN_W-1:0]      i_denom,
    output logic [NUM_W-1:0]      o_quot,
    output drae_pkg::t_div_status o_status
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   shifted;

    assign o_quot          = r_num;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;
    assign shifted         = {r_rem, r_num[NUM_W-1]};

    always_comb begin
        n_num   = r_num;
        n_rem   = r_rem;
        n_den   = r_den;
        n_count = r_count;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (r_busy) begin
            // The partial remainder stays below the divisor, so DEN_W bits hold it.
            if (shifted >= {1'b0, r_den}) begin
                n_rem = DEN_W'(shifted - {1'b0, r_den});
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_num   = i_numer;
            n_den   = i_denom;
            n_rem   = '0;
            n_count = CNT_W'(NUM_W);
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

endmodule

>>> hdl/drae_back.sv
// Back end: sequences the two divisions, updates the average and holds the result word.
module drae_back #(
    parameter int unsigned RATE_WIDTH  = 48,
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned DIV_W       = 33
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [drae_pkg::PERIOD_W-1:0]  i_publish_period,
    input  logic                           i_q_empty,
    input  drae_pkg::t_item                i_q_head,
    output logic                           o_q_pop,
    output logic                           o_div_start,
    output logic [RATE_WIDTH-1:0]          o_div_numer,
    output logic [DIV_W-1:0]               o_div_denom,
    input  logic [RATE_WIDTH-1:0]          i_div_quot,
    input  drae_pkg::t_div_status          i_div_status,
    output logic                           empty,
    input  logic                           pop,
    output logic [RATE_WIDTH-1:0]          o_published_rate,
    output logic [RATE_WIDTH-1:0]          o_average_rate,
    output logic                           o_sample_ignored,
    output logic                           o_rate_published
);

    localparam int unsigned PW = drae_pkg::PERIOD_W;

    drae_pkg::t_back_state   r_state, n_state;
    logic [RATE_WIDTH-1:0]   r_avg, n_avg;
    logic [COUNT_WIDTH-1:0]  r_samples, n_samples;
    logic [PW-1:0]           r_phase, n_phase;
    logic [RATE_WIDTH-1:0]   r_published, n_published;
    logic                    r_ge, n_ge;
    logic                    r_out_valid, n_out_valid;
    logic [RATE_WIDTH-1:0]   r_out_pub, n_out_pub;
    logic [RATE_WIDTH-1:0]   r_out_avg, n_out_avg;
    logic                    r_out_ign, n_out_ign;
    logic                    r_out_flag, n_out_flag;
    logic [PW:0]             phase_sum;
    logic [RATE_WIDTH-1:0]   avg_new;

    assign empty            = !r_out_valid;
    assign o_published_rate = r_out_pub;
    assign o_average_rate   = r_out_avg;
    assign o_sample_ignored = r_out_ign;
    assign o_rate_published = r_out_flag;

    assign phase_sum = {1'b0, r_phase} + 1'b1;
    assign avg_new   = r_ge ? r_avg + i_div_quot : r_avg - i_div_quot;

    always_comb begin
        n_state     = r_state;
        n_avg       = r_avg;
        n_samples   = r_samples;
        n_phase     = r_phase;
        n_published = r_published;
        n_ge        = r_ge;
        n_out_valid = r_out_valid;
        n_out_pub   = r_out_pub;
        n_out_avg   = r_out_avg;
        n_out_ign   = r_out_ign;
        n_out_flag  = r_out_flag;
        o_q_pop     = 1'b0;
        o_div_start = 1'b0;
        o_div_numer = '0;
        o_div_denom = '0;

        if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            drae_pkg::ST_IDLE: begin
                // A new word is taken only once the previous result has left.
                if (!i_q_empty && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_head.ignored) begin
                        n_out_valid = 1'b1;
                        n_out_pub   = r_published;
                        n_out_avg   = r_avg;
                        n_out_ign   = 1'b1;
                        n_out_flag  = 1'b0;
                    end else begin
                        o_div_start = 1'b1;
                        o_div_numer = RATE_WIDTH'(i_q_head.dividend);
                        o_div_denom = DIV_W'(i_q_head.divisor);
                        n_state     = drae_pkg::ST_RATE_DIV;
                    end
                end
            end
            drae_pkg::ST_RATE_DIV: begin
                if (i_div_status.done) begin
                    o_div_start = 1'b1;
                    o_div_denom = DIV_W'(r_samples) + 1'b1;
                    if (i_div_quot >= r_avg) begin
                        n_ge        = 1'b1;
                        o_div_numer = i_div_quot - r_avg;
                    end else begin
                        n_ge        = 1'b0;
                        o_div_numer = r_avg - i_div_quot;
                    end
                    n_state = drae_pkg::ST_AVG_DIV;
                end
            end
            drae_pkg::ST_AVG_DIV: begin
                if (i_div_status.done) begin
                    n_avg = avg_new;
                    if (!(&r_samples)) begin
                        n_samples = r_samples + 1'b1;
                    end
                    n_out_flag = 1'b0;
                    n_out_pub  = r_published;
                    if (phase_sum >= {1'b0, i_publish_period}) begin
                        n_phase     = '0;
                        n_published = avg_new;
                        n_out_flag  = 1'b1;
                        n_out_pub   = avg_new;
                    end else begin
                        n_phase = phase_sum[PW-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_out_avg   = avg_new;
                    n_out_ign   = 1'b0;
                    n_state     = drae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = drae_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drae_pkg::ST_IDLE;
            r_avg       <= '0;
            r_samples   <= '0;
            r_phase     <= '0;
            r_published <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avg       <= n_avg;
            r_samples   <= n_samples;
            r_phase     <= n_phase;
            r_published <= n_published;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ge       <= n_ge;
        r_out_pub  <= n_out_pub;
        r_out_avg  <= n_out_avg;
        r_out_ign  <= n_out_ign;
        r_out_flag <= n_out_flag;
    end

endmodule

>>> hdl/download_rate_average_estimator.sv
// Top level of the download rate average estimator.
//
// Input channel: one word per finished download (byte count, elapsed time),
// taken when push is high and full is low. A two-entry queue sits behind
// the front end, so up to two words are accepted while the back end works.
// Result channel: one word per input word, in order, shown while empty is
// low and taken when pop is high. A word with zero elapsed time goes through
// the queue and then the output register when the back end is idle and holds
// no result; any other word goes through the shared one-bit-per-cycle divider,
// which runs once for the sample rate and once for the averaging step.
// Words are handled one at a time: a new word is taken from the queue only
// after the previous result has been popped. If the receiver does not pop,
// the back end holds its result and stops; the queue then fills and full rises.
// publish_period is written through the APB port at byte address 0; the user
// must write it only while the block is idle; the block itself does not enforce this.
// Reset (synchronous, active low) clears the average, the sample count, the
// phase and the published rate, and sets the period to 5.
module download_rate_average_estimator #(
    parameter int unsigned RATE_WIDTH  = 48,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [drae_pkg::BYTES_W-1:0]       i_byte_count,
    input  logic [drae_pkg::TIME_W-1:0]        i_elapsed_time,
    output logic                               empty,
    input  logic                               pop,
    output logic [RATE_WIDTH-1:0]              o_published_rate,
    output logic [RATE_WIDTH-1:0]              o_average_rate,
    output logic                               o_sample_ignored,
    output logic                               o_rate_published,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drae_pkg::PADDR_W-1:0]       paddr,
    input  logic [drae_pkg::PRDATA_W-1:0]      pwdata,
    output logic [drae_pkg::PRDATA_W-1:0]      prdata,
    output logic                               pready
);

    localparam int unsigned DIV_W = (COUNT_WIDTH + 1 > drae_pkg::TIME_W) ?
                                    COUNT_WIDTH + 1 : drae_pkg::TIME_W;

    logic [drae_pkg::PERIOD_W-1:0] r_publish_period;
    logic                          q_full, q_empty, q_push, q_pop;
    drae_pkg::t_item               q_in_item, q_head;
    logic                          div_start;
    logic [RATE_WIDTH-1:0]         div_numer, div_quot;
    logic [DIV_W-1:0]              div_denom;
    drae_pkg::t_div_status         div_status;

    assign pready = 1'b1;
    assign prdata = (paddr == drae_pkg::ADDR_PUBLISH_PERIOD) ?
                    drae_pkg::PRDATA_W'(r_publish_period) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_publish_period <= drae_pkg::PERIOD_W'(drae_pkg::PERIOD_RESET);
        end else if (psel && penable && pwrite && pready
                     && paddr == drae_pkg::ADDR_PUBLISH_PERIOD) begin
            r_publish_period <= pwdata[drae_pkg::PERIOD_W-1:0];
        end
    end

    drae_front u_front (
        .push           (push),
        .full           (full),
        .i_byte_count   (i_byte_count),
        .i_elapsed_time (i_elapsed_time),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_item       (q_in_item)
    );

    drae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    drae_divider #(
        .NUM_W (RATE_WIDTH),
        .DEN_W (DIV_W)
    ) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_numer  (div_numer),
        .i_denom  (div_denom),
        .o_quot   (div_quot),
        .o_status (div_status)
    );

    drae_back #(
        .RATE_WIDTH  (RATE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .DIV_W       (DIV_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_publish_period (r_publish_period),
        .i_q_empty        (q_empty),
        .i_q_head         (q_head),
        .o_q_pop          (q_pop),
        .o_div_start      (div_start),
        .o_div_numer      (div_numer),
        .o_div_denom      (div_denom),
        .i_div_quot       (div_quot),
        .i_div_status     (div_status),
        .empty            (empty),
        .pop              (pop),
        .o_published_rate (o_published_rate),
        .o_average_rate   (o_average_rate),
        .o_sample_ignored (o_sample_ignored),
        .o_rate_published (o_rate_published)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the download rate average estimator.
module tb;

    localparam int RATE_W       = 48;
    localparam int COUNT_W      = 32;
    localparam int DRAIN_CYCLES = 2 * RATE_W + 8;
    localparam int WORDS_PER_CHUNK = 146;
    localparam int PERIOD_W     = drae_pkg::PERIOD_W;
    localparam int BYTES_W      = drae_pkg::BYTES_W;
    localparam int TIME_W       = drae_pkg::TIME_W;
    localparam int PADDR_W      = drae_pkg::PADDR_W;
    localparam int PRDATA_W     = drae_pkg::PRDATA_W;

    typedef struct packed {
        logic [RATE_W-1:0] published;
        logic [RATE_W-1:0] average;
        logic              ignored;
        logic              publish_flag;
    } t_rate_word;

    // Running model of the estimator and the words it still owes us.
    class rate_scoreboard;
        logic [RATE_W-1:0]   avg_rate;
        logic [RATE_W-1:0]   last_pub;
        logic [COUNT_W-1:0]  seen;
        logic [8:0]          phase;
        logic [PERIOD_W-1:0] period;
        t_rate_word          expected_q[$];
        int                  mismatches;

        function new();
            avg_rate   = '0;
            last_pub   = '0;
            seen       = '0;
            phase      = '0;
            period     = PERIOD_W'(drae_pkg::PERIOD_RESET);
            mismatches = 0;
        endfunction

        function void set_period(logic [PERIOD_W-1:0] value);
            period = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag(string what, logic [63:0] exp_val, logic [63:0] act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", what, exp_val, act_val);
        endfunction

        function void note_word(logic [BYTES_W-1:0] bytes, logic [TIME_W-1:0] span);
            logic [63:0]       scaled;
            logic [63:0]       divisor;
            logic [RATE_W-1:0] rate;
            t_rate_word        w;
            w.ignored      = 1'b0;
            w.publish_flag = 1'b0;
            if (span == '0) begin
                w.ignored = 1'b1;
            end else begin
                scaled  = ({32'b0, bytes} * 64'd8000) / {32'b0, span};
                rate    = scaled[RATE_W-1:0];
                divisor = {32'b0, seen} + 64'd1;
                if (rate >= avg_rate)
                    avg_rate = avg_rate + RATE_W'({16'b0, rate - avg_rate} / divisor);
                else
                    avg_rate = avg_rate - RATE_W'({16'b0, avg_rate - rate} / divisor);
                if (seen != '1)
                    seen = seen + 1'b1;
                phase = phase + 1'b1;
                // A period of zero publishes on every sample, as does a phase
                // that has already passed a newly lowered period.
                if (phase >= {1'b0, period}) begin
                    phase          = '0;
                    last_pub       = avg_rate;
                    w.publish_flag = 1'b1;
                end
            end
            w.published = last_pub;
            w.average   = avg_rate;
            expected_q.push_back(w);
        endfunction

        function void check_result(t_rate_word got);
            t_rate_word want;
            if (expected_q.size() == 0) begin
                flag("unexpected word", 64'd0, 64'd1);
                return;
            end
            want = expected_q.pop_front();
            if (got.published !== want.published)
                flag("published_rate", 64'(want.published), 64'(got.published));
            if (got.average !== want.average)
                flag("average_rate", 64'(want.average), 64'(got.average));
            if (got.ignored !== want.ignored)
                flag("sample_ignored", 64'(want.ignored), 64'(got.ignored));
            if (got.publish_flag !== want.publish_flag)
                flag("rate_published", 64'(want.publish_flag), 64'(got.publish_flag));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [BYTES_W-1:0]  i_byte_count = '0;
    logic [TIME_W-1:0]   i_elapsed_time = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [RATE_W-1:0]   o_published_rate;
    logic [RATE_W-1:0]   o_average_rate;
    logic                o_sample_ignored;
    logic                o_rate_published;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PRDATA_W-1:0] pwdata = '0;
    logic [PRDATA_W-1:0] prdata;
    logic                pready;

    rate_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;

    download_rate_average_estimator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_byte_count     (i_byte_count),
        .i_elapsed_time   (i_elapsed_time),
        .empty            (empty),
        .pop              (pop),
        .o_published_rate (o_published_rate),
        .o_average_rate   (o_average_rate),
        .o_sample_ignored (o_sample_ignored),
        .o_rate_published (o_rate_published),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: take words when offered and pop, stalling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                sb.check_result({o_published_rate, o_average_rate,
                                 o_sample_ignored, o_rate_published});
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_word(input logic [BYTES_W-1:0] bytes, input logic [TIME_W-1:0] span);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_byte_count   <= bytes;
        i_elapsed_time <= span;
        do @(posedge i_clk); while (full);
        sb.note_word(bytes, span);
    endtask

    task automatic send_random_word();
        logic [BYTES_W-1:0] bytes;
        logic [TIME_W-1:0]  span;
        case ($urandom_range(9))
            0:       bytes = '0;
            1:       bytes = '1;
            2, 3, 4: bytes = $urandom_range(100000);
            default: bytes = $urandom;
        endcase
        case ($urandom_range(19))
            0, 1:             span = '0;
            2:                span = '1;
            3:                span = 32'd1;
            4, 5, 6, 7, 8, 9: span = $urandom_range(10000, 1);
            default:          span = $urandom;
        endcase
        send_word(bytes, span);
    endtask

    // The period may only change once every owed word has come back.
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the period, then read it back over the same port.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= drae_pkg::ADDR_PUBLISH_PERIOD;
        pwdata  <= {{(PRDATA_W-PERIOD_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_period(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(PRDATA_W-PERIOD_W){1'b0}}, value})
            sb.flag("publish_period readback", 64'(value), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of both fields under the reset period.
        send_word(32'd0, 32'd0);
        send_word(32'hFFFF_FFFF, 32'd1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd0, 32'd1);
        send_word(32'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'd0);
        send_word(32'd1000, 32'd3);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);

        // Build up a phase under a long period, then cut the period below it.
        wait_idle();
        write_period(8'd255);
        for (int i = 1; i <= 6; i++)
            send_word(32'h1111_1111 * i, 32'(i * 37 + 1));
        wait_idle();
        write_period(8'd2);
        send_word(32'h0012_3456, 32'd77);
        send_word(32'h0000_0400, 32'd9);
        wait_idle();
        write_period(8'd0);
        send_word(32'h7FFF_FFFF, 32'd2);
        send_word(32'd5, 32'd0);
        send_word(32'h0000_FFFF, 32'd100);
        wait_idle();
        write_period(8'd1);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'd12345, 32'd6789);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 26 : (mode == 1) ? 47 : 0;
            recv_idle = (mode == 0) ? 47 : (mode == 1) ? 26 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                wait_idle();
                case (chunk)
                    0:       write_period(PERIOD_W'($urandom_range(8, 1)));
                    1:       write_period(PERIOD_W'($urandom_range(255)));
                    2:       write_period(PERIOD_W'($urandom_range(3, 1)));
                    default: begin
                        case ($urandom_range(2))
                            0:       write_period(8'd0);
                            1:       write_period(8'd1);
                            default: write_period(8'd255);
                        endcase
                    end
                endcase
                repeat (WORDS_PER_CHUNK) send_random_word();
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("download_rate_average_estimator test passed");
        else
            $display("download_rate_average_estimator test failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("download_rate_average_estimator test failed");
        $finish;
    end

endmodule
